@@ hw/rtl/jsud_pkg.sv @@
// Package: payload structs, phase enum, result/error codes and decode helpers for the JSON string decoder
`default_nettype none

package jsud_pkg;

    // Byte constants
    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChZero      = 8'h30;
    localparam logic [7:0] ChLowU      = 8'h75;
    localparam logic [7:0] CtrlLimit   = 8'h20;

    // Register indexes on the config port
    localparam logic RegStoreOutput = 1'b0;
    localparam logic RegCapacity    = 1'b1;

    // Result kinds
    localparam logic [1:0] KindByte  = 2'd0;
    localparam logic [1:0] KindDone  = 2'd1;
    localparam logic [1:0] KindError = 2'd2;

    // Error codes
    localparam logic [2:0] ErrNoQuote      = 3'd0;
    localparam logic [2:0] ErrControl      = 3'd1;
    localparam logic [2:0] ErrEscape       = 3'd2;
    localparam logic [2:0] ErrUnicode      = 3'd3;
    localparam logic [2:0] ErrFull         = 3'd4;
    localparam logic [2:0] ErrUnterminated = 3'd5;
    localparam logic [2:0] ErrNone         = 3'd0;

    typedef enum logic [2:0] {
        PH_FINISHED,
        PH_BODY,
        PH_ESCAPE,
        PH_U0,
        PH_U1,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef struct packed {
        logic       start_of_text;
        logic [7:0] text_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_out;
        logic [2:0] error_code;
    } t_result;

    // Lowercase hex digit: bit 4 flags a valid digit, bits 3:0 the value
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Simple escape map: bit 8 flags a known escape, bits 7:0 the decoded byte
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        case (b)
            8'h22, 8'h5C, 8'h2F: r = {1'b1, b};
            8'h62:               r = {1'b1, 8'h08};
            8'h66:               r = {1'b1, 8'h0C};
            8'h6E:               r = {1'b1, 8'h0A};
            8'h72:               r = {1'b1, 8'h0D};
            8'h74:               r = {1'b1, 8'h09};
            default:             r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/json_string_unescape_parser_top.sv @@
// Top level: JSON string literal decoder, one raw byte per transfer
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (start_of_text, byte)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (kind, data, err code)
//  cfg     | input     | i_cfg_we, i_cfg_index      | i_cfg_data (16 bits)
//
//  One byte per cycle sustained while the output is not stalled; a byte that yields a result
//  sits in the input register, and one decode step then fills the result register.
//  The phase/count update is a single step of small logic, so bytes follow back to back.
//  Reset (i_rst_n low, synchronous) empties both registers, sets phase to finished,
//  store_output to 1 and capacity to 65535.
//  A stall on the output holds the result and backs up into o_in_stall only once the
//  input register also holds a byte.
`default_nettype none

module json_string_unescape_parser_top #(
    parameter int unsigned CAPACITY_MAX = 65535
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire jsud_pkg::t_item  i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output jsud_pkg::t_result     o_out_data,
    input  wire                   i_out_stall,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_index,
    input  wire [15:0]            i_cfg_data
);
    import jsud_pkg::*;

    // Saturation bound clipped to the 16-bit capacity register
    localparam logic [15:0] CapClip =
        (CAPACITY_MAX > 65535) ? 16'hFFFF : CAPACITY_MAX[15:0];

    // Registers
    logic        r_store;
    logic [15:0] r_capacity;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_phase      r_phase;
    logic [3:0]  r_high;
    logic [15:0] r_count;

    // Next values
    t_phase      n_phase;
    logic [3:0]  n_high;
    logic [15:0] n_count;
    logic        n_res_valid;
    t_result     n_res;

    // Step decode
    logic        adv;
    logic [15:0] limit;
    logic        s_fail;
    logic [2:0]  s_code;
    logic        s_done;
    logic        s_emit;
    logic [7:0]  s_val;
    t_phase      s_phase;
    logic        s_full;
    logic        s_store_byte;
    logic [4:0]  hex;
    logic [8:0]  esc;
    logic [7:0]  b;

    assign b     = r_in.text_byte;
    assign hex   = hex_digit(b);
    assign esc   = simple_escape(b);
    assign limit = (r_capacity > CapClip) ? CapClip : r_capacity;

    // Decode stage advances when the input register holds a byte and the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Classify the byte in the input register against the current phase
    always_comb begin
        s_fail  = 1'b0;
        s_code  = ErrNone;
        s_done  = 1'b0;
        s_emit  = 1'b0;
        s_val   = b;
        s_phase = r_phase;
        if (r_in.start_of_text) begin
            if (r_store && limit == 16'd0) begin
                s_fail = 1'b1;
                s_code = ErrFull;
            end else if (b != ChQuote) begin
                s_fail = 1'b1;
                s_code = ErrNoQuote;
            end else begin
                s_phase = PH_BODY;
            end
        end else begin
            unique case (r_phase)
                PH_BODY: begin
                    if (b == 8'h00) begin
                        s_fail = 1'b1;
                        s_code = ErrUnterminated;
                    end else if (b == ChQuote) begin
                        s_done  = 1'b1;
                        s_phase = PH_FINISHED;
                    end else if (b == ChBackslash) begin
                        s_phase = PH_ESCAPE;
                    end else if (b < CtrlLimit) begin
                        s_fail = 1'b1;
                        s_code = ErrControl;
                    end else begin
                        s_emit = 1'b1;
                    end
                end
                PH_ESCAPE: begin
                    s_phase = PH_BODY;
                    if (esc[8]) begin
                        s_emit = 1'b1;
                        s_val  = esc[7:0];
                    end else if (b == ChLowU) begin
                        s_phase = PH_U0;
                    end else begin
                        s_fail = 1'b1;
                        s_code = ErrEscape;
                    end
                end
                PH_U0, PH_U1: begin
                    if (b != ChZero) begin
                        s_fail = 1'b1;
                        s_code = ErrUnicode;
                    end else begin
                        s_phase = (r_phase == PH_U0) ? PH_U1 : PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (!hex[4]) begin
                        s_fail = 1'b1;
                        s_code = ErrUnicode;
                    end else begin
                        s_phase = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (!hex[4]) begin
                        s_fail = 1'b1;
                        s_code = ErrUnicode;
                    end else begin
                        s_phase = PH_BODY;
                        s_emit  = 1'b1;
                        s_val   = {r_high, hex[3:0]};
                    end
                end
                PH_FINISHED: begin
                    s_phase = PH_FINISHED;
                end
                default: begin
                    s_phase = PH_FINISHED;
                end
            endcase
        end
    end

    // Capacity check on a decoded byte in storing mode
    assign s_full       = s_emit && r_store && ({1'b0, r_count} + 17'd1 >= {1'b0, limit});
    assign s_store_byte = s_emit && r_store && !s_full;

    // Next state
    always_comb begin
        n_phase = (s_fail || s_full) ? PH_FINISHED : s_phase;
        n_high  = r_high;
        n_count = r_count;
        if (r_in.start_of_text) begin
            n_high  = 4'd0;
            n_count = 16'd0;
        end else begin
            if (r_phase == PH_HIGH && hex[4]) begin
                n_high = hex[3:0];
            end
            if (s_store_byte) begin
                n_count = r_count + 16'd1;
            end
        end
    end

    // Result
    always_comb begin
        n_res_valid         = s_fail || s_full || s_done || s_store_byte;
        n_res.kind          = KindByte;
        n_res.data_out      = 8'h00;
        n_res.error_code    = ErrNone;
        if (s_fail) begin
            n_res.kind       = KindError;
            n_res.error_code = s_code;
        end else if (s_full) begin
            n_res.kind       = KindError;
            n_res.error_code = ErrFull;
        end else if (s_done) begin
            n_res.kind       = KindDone;
        end else begin
            n_res.data_out   = s_val;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store    <= 1'b1;
            r_capacity <= 16'hFFFF;
        end else if (i_cfg_we) begin
            if (i_cfg_index == RegStoreOutput) begin
                r_store <= i_cfg_data[0];
            end else begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FINISHED;
            r_high  <= 4'd0;
            r_count <= 16'd0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_high  <= n_high;
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && n_res_valid) begin
            r_out <= n_res;
        end
    end

    // Checks
    a_byte_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KindByte |-> o_out_data.error_code == ErrNone)
        else $error("decoded byte carries an error code");

    a_nonbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KindByte |-> o_out_data.data_out == 8'h00)
        else $error("status result carries nonzero data");

    a_byte_needs_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res_valid && n_res.kind == KindByte |-> r_store)
        else $error("decoded byte emitted in validate-only mode");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("input register changed while blocked");

    a_error_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res_valid && n_res.kind == KindError |=> r_phase == PH_FINISHED)
        else $error("parser not finished after error");

endmodule

`default_nettype wire

@@ bench/json_string_unescape_parser_checker.sv @@
// Checker: watches the byte and result channels, predicts each decoded result and compares it
module json_string_unescape_parser_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  jsud_pkg::t_item     i_in_data,
    input  wire                 i_in_stall,
    input  wire                 i_out_valid,
    input  jsud_pkg::t_result   i_out_data,
    input  wire                 i_out_stall,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_index,
    input  wire [15:0]          i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    import jsud_pkg::*;

    localparam logic [7:0] NulByte      = 8'h00;
    // escape letters b f n r t
    localparam logic [7:0] EscBackspace = 8'h62;
    localparam logic [7:0] EscFormFeed  = 8'h66;
    localparam logic [7:0] EscNewline   = 8'h6E;
    localparam logic [7:0] EscReturn    = 8'h72;
    localparam logic [7:0] EscTab       = 8'h74;

    // predicted decoder state and register copies
    t_phase      str_phase;
    logic [3:0]  hi_nib;
    logic [15:0] stored_cnt;
    logic        store_en;
    logic [15:0] cap_bytes;

    t_result     decoded_q[$];

    // lowercase hex digit: bit 4 set when valid
    function automatic logic [4:0] lower_hex_value(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h61 + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic bit make_fail(input logic [2:0] code, output t_result r);
        str_phase = PH_FINISHED;
        r = '{KindError, 8'h00, code};
        return 1'b1;
    endfunction

    // decoded byte: only reported in storing mode, bounded by capacity minus terminator
    function automatic bit store_byte(input logic [7:0] v, output t_result r);
        r = '0;
        if (!store_en) begin
            return 1'b0;
        end
        if ({1'b0, stored_cnt} + 17'd1 >= {1'b0, cap_bytes}) begin
            return make_fail(ErrFull, r);
        end
        stored_cnt = stored_cnt + 16'd1;
        r = '{KindByte, v, ErrNone};
        return 1'b1;
    endfunction

    // one raw byte through the decoder; returns 1 when a result is due
    function automatic bit decode_byte(input t_item it, output t_result r);
        logic [7:0] b;
        logic [4:0] hx;
        b  = it.text_byte;
        hx = lower_hex_value(b);
        r  = '0;
        if (it.start_of_text) begin
            hi_nib     = 4'd0;
            stored_cnt = 16'd0;
            if (store_en && cap_bytes == 16'd0) begin
                return make_fail(ErrFull, r);
            end
            if (b != ChQuote) begin
                return make_fail(ErrNoQuote, r);
            end
            str_phase = PH_BODY;
            return 1'b0;
        end
        case (str_phase)
            PH_BODY: begin
                if (b == NulByte) begin
                    return make_fail(ErrUnterminated, r);
                end
                if (b == ChQuote) begin
                    str_phase = PH_FINISHED;
                    r = '{KindDone, 8'h00, ErrNone};
                    return 1'b1;
                end
                if (b == ChBackslash) begin
                    str_phase = PH_ESCAPE;
                    return 1'b0;
                end
                if (b < CtrlLimit) begin
                    return make_fail(ErrControl, r);
                end
                return store_byte(b, r);
            end
            PH_ESCAPE: begin
                str_phase = PH_BODY;
                case (b)
                    ChQuote, ChBackslash, ChSlash: return store_byte(b, r);
                    EscBackspace: return store_byte(8'h08, r);
                    EscFormFeed:  return store_byte(8'h0C, r);
                    EscNewline:   return store_byte(8'h0A, r);
                    EscReturn:    return store_byte(8'h0D, r);
                    EscTab:       return store_byte(8'h09, r);
                    ChLowU: begin
                        str_phase = PH_U0;
                        return 1'b0;
                    end
                    default: return make_fail(ErrEscape, r);
                endcase
            end
            PH_U0, PH_U1: begin
                if (b != ChZero) begin
                    return make_fail(ErrUnicode, r);
                end
                str_phase = (str_phase == PH_U0) ? PH_U1 : PH_HIGH;
                return 1'b0;
            end
            PH_HIGH: begin
                if (!hx[4]) begin
                    return make_fail(ErrUnicode, r);
                end
                hi_nib    = hx[3:0];
                str_phase = PH_LOW;
                return 1'b0;
            end
            PH_LOW: begin
                if (!hx[4]) begin
                    return make_fail(ErrUnicode, r);
                end
                str_phase = PH_BODY;
                return store_byte({hi_nib, hx[3:0]}, r);
            end
            default: begin
                // finished: bytes without a start are dropped
                str_phase = PH_FINISHED;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            str_phase      = PH_FINISHED;
            hi_nib         = 4'd0;
            stored_cnt     = 16'd0;
            store_en       = 1'b1;
            cap_bytes      = 16'hFFFF;
            o_fail_count   = 0;
            o_result_count = 0;
            decoded_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegStoreOutput) begin
                    store_en = i_cfg_data[0];
                end else begin
                    cap_bytes = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_in_data, want)) begin
                    decoded_q.push_back(want);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                o_result_count = o_result_count + 1;
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: kind %0d data %02h code %0d",
                           got.kind, got.data_out, got.error_code);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.data_out !== want.data_out) begin
                        $error("data_out: expected %02h, got %02h",
                               want.data_out, got.data_out);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, got.error_code);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

@@ bench/tb_json_string_unescape_parser_top.sv @@
// Testbench top: drives byte streams and register settings into the decoder and reports the verdict
module tb_json_string_unescape_parser_top;
    import jsud_pkg::*;

    localparam int IdleLimit = 1000;

    // directed opening: ignored byte, bad start, a clean string with escapes, then broken strings
    localparam logic [8:0] Directed [0:24] = '{
        9'h061, 9'h100,
        9'h122, 9'h041, 9'h0FF, 9'h020, 9'h05C, 9'h06E, 9'h05C, 9'h075,
        9'h030, 9'h030, 9'h030, 9'h030, 9'h022,
        9'h122, 9'h000,
        9'h122, 9'h05C, 9'h000,
        9'h122, 9'h05C, 9'h075, 9'h030, 9'h041
    };

    logic        i_clk;
    logic        rst_n;
    logic        in_valid;
    t_item       in_data;
    logic        in_stall;
    logic        out_valid;
    t_result     out_data;
    logic        out_stall;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int result_count;

    bit calm;
    bit gaps_on;
    int items_sent;
    int strings_sent;
    int settings_count;
    int stall_left;
    int run_left;
    int idle_cycles;

    json_string_unescape_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    json_string_unescape_parser_checker decode_check (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_data      (in_data),
        .i_in_stall     (in_stall),
        .i_out_valid    (out_valid),
        .i_out_data     (out_data),
        .i_out_stall    (out_stall),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stalls in random bursts, none in the calm tail
    always @(negedge i_clk) begin
        if (calm) begin
            out_stall = 1'b0;
        end else if (stall_left > 0) begin
            out_stall  = 1'b1;
            stall_left = stall_left - 1;
        end else begin
            out_stall = 1'b0;
            if (run_left > 0) begin
                run_left = run_left - 1;
            end else begin
                stall_left = $urandom_range(1, 10);
                run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 8);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("json_string_unescape_parser_top: mismatch");
            $finish;
        end
    end

    // one byte transfer; called at a falling edge, returns at a falling edge
    task automatic push_byte(input logic sot, input logic [7:0] b, input bit counted);
        if (!calm && gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = '{start_of_text: sot, text_byte: b};
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        if (counted) begin
            items_sent = items_sent + 1;
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // both registers, only with the decoder idle
    task automatic write_settings(input logic store, input logic [15:0] cap);
        wait_drained();
        // bytes without a result may still be in the two-stage pipe
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = RegStoreOutput;
        cfg_data  = {15'($urandom_range(0, 32767)), store};
        @(negedge i_clk);
        cfg_index = RegCapacity;
        cfg_data  = cap;
        @(negedge i_clk);
        cfg_we = 1'b0;
        settings_count = settings_count + 1;
    endtask

    function automatic logic [7:0] lower_hex(input int n);
        return (n < 10) ? 8'(8'h30 + n) : 8'(8'h61 + n - 10);
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] b);
        return b == ChQuote || b == ChBackslash || b == ChSlash || b == 8'h62 ||
               b == 8'h66 || b == 8'h6E || b == 8'h72 || b == 8'h74 || b == ChLowU;
    endfunction

    // one well-formed body element: plain byte, simple escape or \u00hh
    task automatic send_token();
        int         t;
        logic [7:0] b;
        t = $urandom_range(0, 9);
        if (t < 5) begin
            do b = 8'($urandom_range(32, 255)); while (b == ChQuote || b == ChBackslash);
            push_byte(1'b0, b, 1'b1);
        end else if (t < 7) begin
            do b = 8'($urandom_range(32, 127)); while (!is_escape_letter(b) || b == ChLowU);
            push_byte(1'b0, ChBackslash, 1'b1);
            push_byte(1'b0, b, 1'b1);
        end else begin
            push_byte(1'b0, ChBackslash, 1'b1);
            push_byte(1'b0, ChLowU, 1'b1);
            push_byte(1'b0, ChZero, 1'b1);
            push_byte(1'b0, ChZero, 1'b1);
            push_byte(1'b0, lower_hex($urandom_range(0, 15)), 1'b1);
            push_byte(1'b0, lower_hex($urandom_range(0, 15)), 1'b1);
        end
    endtask

    // one body element that ends the string with an error
    task automatic send_broken();
        int         t;
        logic [7:0] b;
        logic [4:0] pos;
        t = $urandom_range(0, 6);
        case (t)
            0: push_byte(1'b0, 8'($urandom_range(1, 31)), 1'b1);
            1: push_byte(1'b0, 8'h00, 1'b1);
            2: begin
                // unknown escape letter, zero byte included
                do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
                push_byte(1'b0, ChBackslash, 1'b1);
                push_byte(1'b0, b, 1'b1);
            end
            3: begin
                // \u with something other than 00
                do b = 8'($urandom_range(0, 255)); while (b == ChZero);
                push_byte(1'b0, ChBackslash, 1'b1);
                push_byte(1'b0, ChLowU, 1'b1);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(1'b0, ChZero, 1'b1);
                end
                push_byte(1'b0, b, 1'b1);
            end
            4: begin
                // uppercase or non-hex digit in either nibble
                if ($urandom_range(0, 1) == 1) begin
                    b = 8'($urandom_range(8'h41, 8'h46));
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66));
                end
                push_byte(1'b0, ChBackslash, 1'b1);
                push_byte(1'b0, ChLowU, 1'b1);
                push_byte(1'b0, ChZero, 1'b1);
                push_byte(1'b0, ChZero, 1'b1);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(1'b0, lower_hex($urandom_range(0, 15)), 1'b1);
                end
                push_byte(1'b0, b, 1'b1);
            end
            5: begin
                // zero byte somewhere inside \u00hh
                pos = 5'($urandom_range(0, 3));
                push_byte(1'b0, ChBackslash, 1'b1);
                push_byte(1'b0, ChLowU, 1'b1);
                if (pos > 0) push_byte(1'b0, ChZero, 1'b1);
                if (pos > 1) push_byte(1'b0, ChZero, 1'b1);
                if (pos > 2) push_byte(1'b0, lower_hex($urandom_range(0, 15)), 1'b1);
                push_byte(1'b0, 8'h00, 1'b1);
            end
            default: begin
                push_byte(1'b0, ChBackslash, 1'b1);
                push_byte(1'b0, 8'h00, 1'b1);
            end
        endcase
    endtask

    // mostly well-formed strings, some broken, some noise
    task automatic send_string();
        int mode;
        int n;
        int k;
        int bad_at;
        mode    = $urandom_range(0, 99);
        gaps_on = ($urandom_range(0, 3) != 0);
        strings_sent = strings_sent + 1;
        if (mode < 10) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                push_byte($urandom_range(0, 3) == 0,
                          ($urandom_range(0, 3) == 0) ? ChQuote : 8'($urandom_range(0, 255)),
                          1'b1);
            end
        end else begin
            if (mode < 14) begin
                push_byte(1'b1, 8'($urandom_range(0, 255)), 1'b1);
            end else begin
                push_byte(1'b1, ChQuote, 1'b1);
            end
            n      = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
            bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : -1;
            for (k = 0; k < n && k != bad_at; k++) begin
                send_token();
            end
            if (bad_at >= 0) begin
                send_broken();
            end else if ($urandom_range(0, 9) == 0) begin
                push_byte(1'b0, 8'h00, 1'b1);
            end else begin
                push_byte(1'b0, ChQuote, 1'b1);
            end
        end
        // trailing bytes after a finished string are dropped by the block
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic run_strings(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_string();
    endtask

    initial begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = RegStoreOutput;
        cfg_data       = 16'd0;
        calm           = 1'b0;
        gaps_on        = 1'b1;
        items_sent     = 0;
        strings_sent   = 0;
        settings_count = 0;
        stall_left     = 0;
        run_left       = 0;
        idle_cycles    = 0;
        repeat (7) @(negedge i_clk);
        rst_n = 1'b1;
        @(negedge i_clk);

        // reset settings: storing, full capacity
        for (int i = 0; i < 25; i++) begin
            push_byte(Directed[i][8], Directed[i][7:0], 1'b1);
        end
        run_strings(200);
        // hold the sender until every pending result has come back
        wait_drained();
        run_strings(150);

        write_settings(1'b0, 16'hFFFF);
        run_strings(200);
        write_settings(1'b1, 16'd1);
        run_strings(100);
        write_settings(1'b1, 16'd5);
        run_strings(200);
        write_settings(1'b1, 16'd0);
        run_strings(60);
        write_settings(1'b0, 16'd0);
        run_strings(100);
        write_settings(1'b1, 16'($urandom_range(2, 20)));
        run_strings(200);
        write_settings(1'b1, 16'hFFFF);
        calm = 1'b1;
        run_strings(300);

        wait_drained();
        repeat (8) @(negedge i_clk);
        $display("sent %0d bytes in %0d strings over %0d register settings, %0d results checked",
                 items_sent, strings_sent, settings_count, result_count);
        $display("settings spanned validate-only mode and capacities 0, 1, small and 65535");
        if (fail_count == 0) begin
            $display("json_string_unescape_parser_top: match");
        end else begin
            $display("json_string_unescape_parser_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/jsud_pkg.sv
hw/rtl/json_string_unescape_parser_top.sv
bench/json_string_unescape_parser_checker.sv
bench/tb_json_string_unescape_parser_top.sv
